// ----- rtl/core/owik_pkg.sv -----
// Shared types and constants for the omni wheel inverse kinematics block.
// Depends on nothing; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package owik_pkg;

    // Register indexes of the configuration port.
    localparam logic [2:0] REG_WHEEL_RADIUS = 3'd0;
    localparam logic [2:0] REG_WHEELBASE    = 3'd1;
    localparam logic [2:0] REG_TRACK_WIDTH  = 3'd2;
    localparam logic [2:0] REG_SPEED_LIMIT  = 3'd3;

    localparam logic [31:0] RST_WHEEL_RADIUS = 32'd3277;
    localparam logic [31:0] RST_WHEELBASE    = 32'd19661;
    localparam logic [31:0] RST_TRACK_WIDTH  = 32'd19661;
    localparam logic [31:0] RST_SPEED_LIMIT  = 32'd1310720;

    // sqrt(1/2) in unsigned Q.30.
    localparam logic [31:0] DIAG_Q30 = 32'd759250125;

    localparam int WHEEL_COUNT = 4;
    localparam int QUEUE_DEPTH = 2;
    localparam int DIV_STEPS   = 96;
    localparam int SQRT_STEPS  = 32;

    typedef struct packed {
        logic [31:0] wheel_radius;
        logic [31:0] wheelbase_length;
        logic [31:0] track_width;
        logic [31:0] speed_limit;
    } cfg_t;

    // One classified twist waiting between the front and the back.
    typedef struct packed {
        logic [31:0] vel_x;
        logic [31:0] vel_y;
        logic [31:0] yaw_rate;
        logic        ok;
    } entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LSQ,
        ST_TSQ,
        ST_SQRT,
        ST_DA,
        ST_DB,
        ST_ARM,
        ST_BOUND,
        ST_MAX,
        ST_PLO,
        ST_PHI,
        ST_LOAD,
        ST_DIV,
        ST_SAT,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

// ----- rtl/core/owik_front.sv -----
// Front part: configuration registers, input item acceptance and classification.
// Depends on owik_pkg.
`timescale 1ns / 1ps
`default_nettype none

module owik_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [2:0]        cfg_index,
    input  wire logic [31:0]       cfg_data,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [31:0]       vel_x,
    input  wire logic [31:0]       vel_y,
    input  wire logic [31:0]       yaw_rate,
    input  wire logic              queue_full,
    output logic                   push,
    output owik_pkg::entry_t       push_entry,
    output owik_pkg::cfg_t         cfg
);

    owik_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Register writes; indexes beyond the list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.wheel_radius     <= owik_pkg::RST_WHEEL_RADIUS;
            cfg_reg.wheelbase_length <= owik_pkg::RST_WHEELBASE;
            cfg_reg.track_width      <= owik_pkg::RST_TRACK_WIDTH;
            cfg_reg.speed_limit      <= owik_pkg::RST_SPEED_LIMIT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                owik_pkg::REG_WHEEL_RADIUS: cfg_reg.wheel_radius     <= cfg_data;
                owik_pkg::REG_WHEELBASE:    cfg_reg.wheelbase_length <= cfg_data;
                owik_pkg::REG_TRACK_WIDTH:  cfg_reg.track_width      <= cfg_data;
                owik_pkg::REG_SPEED_LIMIT:  cfg_reg.speed_limit      <= cfg_data;
                default: ;
            endcase
        end
    end

    // An item is taken whenever the queue has room; it is tagged with the geometry check.
    assign in_stall = queue_full;
    assign push     = in_valid && !queue_full;

    always_comb
    begin
        push_entry.vel_x    = vel_x;
        push_entry.vel_y    = vel_y;
        push_entry.yaw_rate = yaw_rate;
        push_entry.ok       = (cfg_reg.wheel_radius != 32'd0) &&
                              (cfg_reg.wheelbase_length != 32'd0) &&
                              (cfg_reg.track_width != 32'd0) &&
                              (cfg_reg.speed_limit != 32'd0);
    end

endmodule

`default_nettype wire

// ----- rtl/core/owik_queue.sv -----
// Short queue of classified items between the front and the back.
// Depends on owik_pkg.
`timescale 1ns / 1ps
`default_nettype none

module owik_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire owik_pkg::entry_t  push_entry,
    input  wire logic              pop,
    output owik_pkg::entry_t       pop_entry,
    output logic                   full,
    output logic                   empty
);

    localparam int PTR_W = $clog2(owik_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(owik_pkg::QUEUE_DEPTH + 1);

    owik_pkg::entry_t   mem_reg [owik_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    assign full      = (count_reg == CNT_W'(owik_pkg::QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign pop_entry = mem_reg[rd_ptr_reg];

    // Storage for the entries.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/owik_back.sv -----
// Back part: sequencer with a shared multiplier, square root and bit-serial divider,
// plus the output register. Depends on owik_pkg.
`timescale 1ns / 1ps
`default_nettype none

module owik_back #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire owik_pkg::cfg_t    cfg,
    input  wire owik_pkg::entry_t  pop_entry,
    input  wire logic              queue_empty,
    output logic                   pop,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [31:0]            wheel_speed_0,
    output logic [31:0]            wheel_speed_1,
    output logic [31:0]            wheel_speed_2,
    output logic [31:0]            wheel_speed_3,
    output logic                   ok,
    output logic                   limited
);

    localparam int DIAG_SHIFT = 30 - FRAC_BITS;
    localparam int WC         = owik_pkg::WHEEL_COUNT;

    owik_pkg::state_t state_reg, state_next;

    logic [6:0]   step_reg;
    logic [1:0]   wheel_reg;
    logic [31:0]  vx_reg, vy_reg, wz_reg;
    logic         ok_item_reg;
    logic [63:0]  lsq_reg;
    logic [63:0]  sq_x_reg, sq_res_reg, sq_bit_reg;
    logic [63:0]  a_mag_reg, b_mag_reg, r_mag_reg;
    logic [63:0]  bound_reg, nmax_reg;
    logic [63:0]  mag_reg [WC];
    logic         neg_reg [WC];
    logic         lim_reg;
    logic [63:0]  plo_reg, phi_reg;
    logic [95:0]  dq_reg;
    logic [63:0]  rem_reg, divisor_reg;
    logic [31:0]  speed_reg [WC];

    logic         out_valid_reg;
    logic [31:0]  out_speed_reg [WC];
    logic         out_ok_reg, out_lim_reg;

    // Twist combinations.
    logic signed [32:0] sum_s, dif_s;
    logic [32:0]        sum_mag, dif_mag, wz_mag;
    logic               sum_neg, dif_neg, wz_neg;

    always_comb
    begin
        sum_s   = $signed({vx_reg[31], vx_reg}) + $signed({vy_reg[31], vy_reg});
        dif_s   = $signed({vx_reg[31], vx_reg}) - $signed({vy_reg[31], vy_reg});
        sum_neg = sum_s[32];
        dif_neg = dif_s[32];
        wz_neg  = wz_reg[31];
        sum_mag = sum_neg ? 33'(-sum_s) : 33'(sum_s);
        dif_mag = dif_neg ? 33'(-dif_s) : 33'(dif_s);
        wz_mag  = wz_neg ? 33'(-$signed({wz_reg[31], wz_reg})) : {1'b0, wz_reg};
    end

    // Shared multiplier operand selection.
    logic [32:0] mul_a;
    logic [31:0] mul_b;
    logic [64:0] mul_p;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            owik_pkg::ST_LSQ:
            begin
                mul_a = {1'b0, cfg.wheelbase_length};
                mul_b = cfg.wheelbase_length;
            end
            owik_pkg::ST_TSQ:
            begin
                mul_a = {1'b0, cfg.track_width};
                mul_b = cfg.track_width;
            end
            owik_pkg::ST_DA:
            begin
                mul_a = sum_mag;
                mul_b = owik_pkg::DIAG_Q30;
            end
            owik_pkg::ST_DB:
            begin
                mul_a = dif_mag;
                mul_b = owik_pkg::DIAG_Q30;
            end
            owik_pkg::ST_ARM:
            begin
                mul_a = {1'b0, sq_res_reg[31:0]};
                mul_b = wz_mag[31:0];
            end
            owik_pkg::ST_BOUND:
            begin
                mul_a = {1'b0, cfg.speed_limit};
                mul_b = cfg.wheel_radius;
            end
            owik_pkg::ST_PLO:
            begin
                mul_a = {1'b0, mag_reg[wheel_reg][31:0]};
                mul_b = cfg.speed_limit;
            end
            owik_pkg::ST_PHI:
            begin
                mul_a = {1'b0, mag_reg[wheel_reg][63:32]};
                mul_b = cfg.speed_limit;
            end
            default: ;
        endcase
        mul_p = 65'(mul_a) * 65'(mul_b);
    end

    // Wheel numerators and their largest magnitude.
    logic signed [65:0] a_s, b_s, r_s;
    logic signed [65:0] num [WC];
    logic [63:0]        num_mag [WC];
    logic [63:0]        max01, max23, max_all;

    always_comb
    begin
        a_s = sum_neg ? -$signed({2'b00, a_mag_reg}) : $signed({2'b00, a_mag_reg});
        b_s = dif_neg ? -$signed({2'b00, b_mag_reg}) : $signed({2'b00, b_mag_reg});
        r_s = wz_neg  ? -$signed({2'b00, r_mag_reg}) : $signed({2'b00, r_mag_reg});
        num[0] = a_s + r_s;
        num[1] = r_s - b_s;
        num[2] = r_s - a_s;
        num[3] = b_s + r_s;
        for (int i = 0; i < WC; i++)
        begin
            num_mag[i] = num[i][65] ? 64'(-num[i]) : num[i][63:0];
        end
        max01   = (num_mag[1] > num_mag[0]) ? num_mag[1] : num_mag[0];
        max23   = (num_mag[3] > num_mag[2]) ? num_mag[3] : num_mag[2];
        max_all = (max23 > max01) ? max23 : max01;
    end

    // Square root step and divider step.
    logic [64:0] sq_trial;
    logic        sq_take;
    logic [64:0] div_trial;
    logic        div_take;
    logic [95:0] quarter_sum;

    always_comb
    begin
        sq_trial    = {1'b0, sq_res_reg} + {1'b0, sq_bit_reg};
        sq_take     = ({1'b0, sq_x_reg} >= sq_trial);
        div_trial   = {rem_reg, dq_reg[95]};
        div_take    = (div_trial >= {1'b0, divisor_reg});
        quarter_sum = {32'd0, lsq_reg} + {32'd0, mul_p[63:0]};
    end

    // Saturation of the finished quotient.
    logic [31:0] sat_val;
    logic        q_hi_nz;

    always_comb
    begin
        q_hi_nz = |dq_reg[95:32];
        if (neg_reg[wheel_reg])
        begin
            if (q_hi_nz || (dq_reg[31:0] > 32'h8000_0000))
            begin
                sat_val = 32'h8000_0000;
            end
            else
            begin
                sat_val = -dq_reg[31:0];
            end
        end
        else if (q_hi_nz || dq_reg[31])
        begin
            sat_val = 32'h7FFF_FFFF;
        end
        else
        begin
            sat_val = dq_reg[31:0];
        end
    end

    logic out_take;
    logic out_load;

    assign out_take = out_valid_reg && !out_stall;
    assign out_load = (state_reg == owik_pkg::ST_DONE) && (!out_valid_reg || !out_stall);
    assign pop      = (state_reg == owik_pkg::ST_IDLE) && !queue_empty;

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            owik_pkg::ST_IDLE:
            begin
                if (!queue_empty)
                begin
                    state_next = pop_entry.ok ? owik_pkg::ST_LSQ : owik_pkg::ST_DONE;
                end
            end
            owik_pkg::ST_LSQ:   state_next = owik_pkg::ST_TSQ;
            owik_pkg::ST_TSQ:   state_next = owik_pkg::ST_SQRT;
            owik_pkg::ST_SQRT:
            begin
                if (step_reg == 7'(owik_pkg::SQRT_STEPS - 1))
                begin
                    state_next = owik_pkg::ST_DA;
                end
            end
            owik_pkg::ST_DA:    state_next = owik_pkg::ST_DB;
            owik_pkg::ST_DB:    state_next = owik_pkg::ST_ARM;
            owik_pkg::ST_ARM:   state_next = owik_pkg::ST_BOUND;
            owik_pkg::ST_BOUND: state_next = owik_pkg::ST_MAX;
            owik_pkg::ST_MAX:
            begin
                state_next = (max_all > bound_reg) ? owik_pkg::ST_PLO : owik_pkg::ST_LOAD;
            end
            owik_pkg::ST_PLO:   state_next = owik_pkg::ST_PHI;
            owik_pkg::ST_PHI:   state_next = owik_pkg::ST_LOAD;
            owik_pkg::ST_LOAD:  state_next = owik_pkg::ST_DIV;
            owik_pkg::ST_DIV:
            begin
                if (step_reg == 7'(owik_pkg::DIV_STEPS - 1))
                begin
                    state_next = owik_pkg::ST_SAT;
                end
            end
            owik_pkg::ST_SAT:
            begin
                if (wheel_reg == 2'(WC - 1))
                begin
                    state_next = owik_pkg::ST_DONE;
                end
                else
                begin
                    state_next = lim_reg ? owik_pkg::ST_PLO : owik_pkg::ST_LOAD;
                end
            end
            owik_pkg::ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = owik_pkg::ST_IDLE;
                end
            end
            default:            state_next = owik_pkg::ST_IDLE;
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= owik_pkg::ST_IDLE;
            step_reg      <= '0;
            wheel_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (((state_reg == owik_pkg::ST_SQRT) || (state_reg == owik_pkg::ST_DIV)) &&
                (state_next == state_reg))
            begin
                step_reg <= step_reg + 7'd1;
            end
            else
            begin
                step_reg <= '0;
            end
            if (state_reg == owik_pkg::ST_IDLE)
            begin
                wheel_reg <= '0;
            end
            else if (state_reg == owik_pkg::ST_SAT)
            begin
                wheel_reg <= wheel_reg + 2'd1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            owik_pkg::ST_IDLE:
            begin
                vx_reg      <= pop_entry.vel_x;
                vy_reg      <= pop_entry.vel_y;
                wz_reg      <= pop_entry.yaw_rate;
                ok_item_reg <= pop_entry.ok;
                lim_reg     <= 1'b0;
                for (int i = 0; i < WC; i++)
                begin
                    speed_reg[i] <= '0;
                end
            end
            owik_pkg::ST_LSQ:
            begin
                lsq_reg <= mul_p[63:0];
            end
            owik_pkg::ST_TSQ:
            begin
                sq_x_reg   <= quarter_sum[65:2];
                sq_res_reg <= '0;
                sq_bit_reg <= 64'd1 << 62;
            end
            owik_pkg::ST_SQRT:
            begin
                if (sq_take)
                begin
                    sq_x_reg   <= sq_x_reg - sq_trial[63:0];
                    sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
                end
                else
                begin
                    sq_res_reg <= sq_res_reg >> 1;
                end
                sq_bit_reg <= sq_bit_reg >> 2;
            end
            owik_pkg::ST_DA:
            begin
                a_mag_reg <= 64'(mul_p >> DIAG_SHIFT);
            end
            owik_pkg::ST_DB:
            begin
                b_mag_reg <= 64'(mul_p >> DIAG_SHIFT);
            end
            owik_pkg::ST_ARM:
            begin
                r_mag_reg <= mul_p[63:0];
            end
            owik_pkg::ST_BOUND:
            begin
                bound_reg <= mul_p[63:0];
            end
            owik_pkg::ST_MAX:
            begin
                nmax_reg <= max_all;
                lim_reg  <= (max_all > bound_reg);
                for (int i = 0; i < WC; i++)
                begin
                    mag_reg[i] <= num_mag[i];
                    neg_reg[i] <= num[i][65];
                end
            end
            owik_pkg::ST_PLO:
            begin
                plo_reg <= mul_p[63:0];
            end
            owik_pkg::ST_PHI:
            begin
                phi_reg <= mul_p[63:0];
            end
            owik_pkg::ST_LOAD:
            begin
                rem_reg <= '0;
                if (lim_reg)
                begin
                    dq_reg      <= {phi_reg, 32'd0} + {32'd0, plo_reg};
                    divisor_reg <= nmax_reg;
                end
                else
                begin
                    dq_reg      <= {32'd0, mag_reg[wheel_reg]};
                    divisor_reg <= {32'd0, cfg.wheel_radius};
                end
            end
            owik_pkg::ST_DIV:
            begin
                rem_reg <= div_take ? 64'(div_trial - {1'b0, divisor_reg}) : div_trial[63:0];
                dq_reg  <= {dq_reg[94:0], div_take};
            end
            owik_pkg::ST_SAT:
            begin
                speed_reg[wheel_reg] <= sat_val;
            end
            default: ;
        endcase
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            for (int i = 0; i < WC; i++)
            begin
                out_speed_reg[i] <= speed_reg[i];
            end
            out_ok_reg  <= ok_item_reg;
            out_lim_reg <= lim_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign wheel_speed_0 = out_speed_reg[0];
    assign wheel_speed_1 = out_speed_reg[1];
    assign wheel_speed_2 = out_speed_reg[2];
    assign wheel_speed_3 = out_speed_reg[3];
    assign ok            = out_ok_reg;
    assign limited       = out_lim_reg;

    // An invalid geometry item must carry zero speeds and no limit flag.
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ok_reg |->
            !out_lim_reg && (out_speed_reg[0] == 32'd0) && (out_speed_reg[1] == 32'd0) &&
            (out_speed_reg[2] == 32'd0) && (out_speed_reg[3] == 32'd0))
        else $error("invalid item carries nonzero speeds");

    // A division, scaled or not, never divides by zero.
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == owik_pkg::ST_DIV) |-> (divisor_reg != 64'd0))
        else $error("divider started with a zero divisor");

    // The divider runs exactly its step count before saturation.
    a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == owik_pkg::ST_SAT) |->
            $past(state_reg) == owik_pkg::ST_DIV &&
            $past(step_reg) == 7'(owik_pkg::DIV_STEPS - 1))
        else $error("divider left early");

    // A result never overwrites one that is still stalled.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |=> $stable(out_speed_reg[0]) && $stable(out_ok_reg))
        else $error("stalled result changed");

endmodule

`default_nettype wire

// ----- rtl/core/omni_wheel_inverse_kinematics_top.sv -----
// Top level of the X-drive omni wheel inverse kinematics block.
// Depends on owik_pkg, owik_front, owik_queue and owik_back.
//
//  Channel  Direction  Handshake             Payload
//  cfg      in         cfg_valid/cfg_ready   cfg_index, cfg_data
//  in       in         in_valid/in_stall     vel_x, vel_y, yaw_rate
//  out      out        out_valid/out_stall   wheel_speed_0..3, ok, limited
//
// The 96-step bit-serial divider, run once per wheel, takes most of the back part's time
// for an item with valid geometry. An item with a zero register goes straight to done.
// A two-entry queue lets the front accept items while the back works, and the output
// register holds a stalled result while the back goes on. Reset loads the register
// defaults and empties queue and output.
`timescale 1ns / 1ps
`default_nettype none

module omni_wheel_inverse_kinematics_top #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [31:0]  cfg_data,
    input  wire logic         in_valid,
    output logic              in_stall,
    input  wire logic [31:0]  vel_x,
    input  wire logic [31:0]  vel_y,
    input  wire logic [31:0]  yaw_rate,
    output logic              out_valid,
    input  wire logic         out_stall,
    output logic [31:0]       wheel_speed_0,
    output logic [31:0]       wheel_speed_1,
    output logic [31:0]       wheel_speed_2,
    output logic [31:0]       wheel_speed_3,
    output logic              ok,
    output logic              limited
);

    owik_pkg::cfg_t   cfg;
    owik_pkg::entry_t push_entry;
    owik_pkg::entry_t pop_entry;
    logic             push;
    logic             pop;
    logic             queue_full;
    logic             queue_empty;

    owik_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .vel_x      (vel_x),
        .vel_y      (vel_y),
        .yaw_rate   (yaw_rate),
        .queue_full (queue_full),
        .push       (push),
        .push_entry (push_entry),
        .cfg        (cfg)
    );

    owik_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .full       (queue_full),
        .empty      (queue_empty)
    );

    owik_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .pop_entry     (pop_entry),
        .queue_empty   (queue_empty),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .wheel_speed_0 (wheel_speed_0),
        .wheel_speed_1 (wheel_speed_1),
        .wheel_speed_2 (wheel_speed_2),
        .wheel_speed_3 (wheel_speed_3),
        .ok            (ok),
        .limited       (limited)
    );

endmodule

`default_nettype wire
